[hw/rtl/necs_pkg.sv]
// ----------------------------------------------------------------------------
// necs_pkg: shared constants for the segment cost unit
// Fixed-point constants, step counts and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package necs_pkg;

    localparam logic [15:0] ONE_Q88  = 16'd256;
    localparam logic [15:0] ONE_Q214 = 16'd16384;
    localparam logic [15:0] TWO_Q214 = 16'd32768;

    localparam int SQ_STEPS     = 33;   // magnitude bits per square
    localparam int HROOT_STEPS  = 41;   // digit pairs of the horizontal root
    localparam int LROOT_STEPS  = 33;   // digit pairs of the length root
    localparam int CORDIC_STEPS = 20;
    localparam int DIV_STEPS    = 19;   // quotient bits of the divide by 25
    localparam int MUL_STEPS    = 33;   // length bits in the cost product

    localparam logic [5:0]  DIV_BY       = 6'd25;
    localparam logic [27:0] CLAMP_Q      = 28'd409600;  // 16384 * 25
    localparam logic [39:0] FACT_ROUND   = 40'd51200;
    localparam logic [66:0] COST_ROUND   = 67'd2097152;  // 2^21

    localparam logic [1:0] OP_COST  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_BEGIN = 2'd2;

    localparam logic [1:0] REG_COEF     = 2'd0;
    localparam logic [1:0] REG_ROAD_DIS = 2'd1;
    localparam logic [1:0] REG_ROAD_ID  = 2'd2;

    // atan(2^-i) in degrees, Q.16
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/navmesh_edge_cost_slope.sv]
// ----------------------------------------------------------------------------
// navmesh_edge_cost_slope: path segment cost with area and slope weighting
// Serial squares, square roots, CORDIC angle, divide and cost product.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one request per segment; tuser carries the opcode, tdata the
//   endpoints, area class and table value. s_axis_tready is high only while
//   the unit is idle, so one request is in flight at a time.
//   m_axis: one result per request (cost, slope factor, peak slope factor).
//   cfg: write-only register port, taken on any cycle with cfg_we high.
// Sequence
//   Cost requests run the serial squares, the two bit-pair square roots (the
//   length root alongside the horizontal one), the CORDIC steps, the divide
//   by 25 and the bit-serial cost product, with set-up states between them
//   and a hand-over state at the end. The unit takes the next request only
//   after it returns to idle, so one cost request is in flight at a time.
//   Table writes, begin-path and no-op requests go straight to the hand-over
//   state; a new request is taken once that result has been handed over.
// Reset
//   Area cost table reads 1.0 everywhere, peak slope 1.0, registers to
//   their defaults. No clearing pass: valid bits cover the table.
// Stall
//   A finished result sits in the output register; the unit holds the next
//   result until that one is taken, and stays busy meanwhile.
module navmesh_edge_cost_slope #(
    parameter int AREA_COUNT = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] start_x, [63:32] start_y, [95:64] start_z, [127:96] end_x,
    // [159:128] end_y, [191:160] end_z, [197:192] area_class,
    // [213:198] area_cost_value, [215:214] zero
    input  logic [215:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [47:0] edge_cost, [63:48] slope_factor, [79:64] max_slope_factor
    output logic [79:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import necs_pkg::*;

    localparam int AW = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQR   = 4'd1;
    localparam logic [3:0] ST_SUM   = 4'd2;
    localparam logic [3:0] ST_ROOT  = 4'd3;
    localparam logic [3:0] ST_CINIT = 4'd4;
    localparam logic [3:0] ST_CORD  = 4'd5;
    localparam logic [3:0] ST_FACT  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FAC   = 4'd8;
    localparam logic [3:0] ST_PRD   = 4'd9;
    localparam logic [3:0] ST_MUL   = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    function automatic logic [32:0] mag33(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? (~d + 33'd1) : d;
    endfunction

    // configuration
    logic [15:0] coef_reg;
    logic        road_dis_reg;
    logic [5:0]  road_id_reg;

    // control
    logic [3:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        out_vld_reg;
    logic [79:0] out_data_reg;
    logic [15:0] peak_reg;

    // table
    logic [15:0]           area_mem [AREA_COUNT];
    logic [AREA_COUNT-1:0] area_vld_reg;
    logic [15:0]           mem_rd_reg;
    logic                  hit_reg;
    logic                  road_ovr_reg;

    // datapath
    logic        vert_reg;
    logic [32:0] ax_reg, ay_reg, az_reg;
    logic [32:0] qx_reg, qy_reg, qz_reg;
    logic [65:0] sx_reg, sy_reg, sz_reg;
    logic [81:0] hv_reg;
    logic [65:0] lv_reg;
    logic [44:0] hrem_reg;
    logic [40:0] hroot_reg;
    logic [36:0] lrem_reg;
    logic [32:0] lroot_reg;
    logic signed [59:0] cx_reg, cy_reg;
    logic signed [23:0] cz_reg;
    logic        zpos_reg, clamp_reg;
    logic [18:0] dq_reg;
    logic [4:0]  drem_reg;
    logic [13:0] quot_reg;
    logic [15:0] fac_reg;
    logic [31:0] p_reg;
    logic [32:0] ml_reg;
    logic [65:0] macc_reg;
    logic [47:0] res_cost_reg;
    logic [15:0] res_fac_reg;
    logic [15:0] res_max_reg;

    // input fields
    logic [31:0] in_sx, in_sy, in_sz, in_ex, in_ey, in_ez;
    logic [5:0]  in_area;
    logic [15:0] in_val;
    logic        in_rng;
    logic [AW-1:0] in_idx;
    logic        acc;
    logic        out_load;

    assign in_sx   = s_axis_tdata[31:0];
    assign in_sy   = s_axis_tdata[63:32];
    assign in_sz   = s_axis_tdata[95:64];
    assign in_ex   = s_axis_tdata[127:96];
    assign in_ey   = s_axis_tdata[159:128];
    assign in_ez   = s_axis_tdata[191:160];
    assign in_area = s_axis_tdata[197:192];
    assign in_val  = s_axis_tdata[213:198];
    assign in_rng  = ({1'b0, in_area} < 7'(AREA_COUNT));
    assign in_idx  = AW'(in_area);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!out_vld_reg || m_axis_tready);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // serial step logic
    logic [65:0] sx_next, sy_next, sz_next;
    logic [44:0] hrem_sh, htrial;
    logic [36:0] lrem_sh, ltrial;
    logic signed [59:0] xs, ys;
    logic signed [23:0] tz;
    logic [39:0] fv;
    logic [5:0]  dsh;
    logic [15:0] acost;
    logic [15:0] fac_calc;
    logic [66:0] csum;

    always_comb
    begin
        sx_next  = {sx_reg[64:0], 1'b0} + (qx_reg[32] ? {33'd0, ax_reg} : 66'd0);
        sy_next  = {sy_reg[64:0], 1'b0} + (qy_reg[32] ? {33'd0, ay_reg} : 66'd0);
        sz_next  = {sz_reg[64:0], 1'b0} + (qz_reg[32] ? {33'd0, az_reg} : 66'd0);
        hrem_sh  = {hrem_reg[42:0], hv_reg[81:80]};
        htrial   = {2'b00, hroot_reg, 2'b01};
        lrem_sh  = {lrem_reg[34:0], lv_reg[65:64]};
        ltrial   = {2'b00, lroot_reg, 2'b01};
        xs       = cx_reg >>> cnt_reg[4:0];
        ys       = cy_reg >>> cnt_reg[4:0];
        tz       = {2'b00, atan_deg(cnt_reg[4:0])};
        fv       = 40'(39'(cz_reg[22:0]) * 39'(coef_reg)) + FACT_ROUND;
        dsh      = {drem_reg, dq_reg[18]};
        acost    = (road_ovr_reg || !hit_reg) ? ONE_Q88 : mem_rd_reg;
        if (vert_reg || !zpos_reg)
            fac_calc = ONE_Q214;
        else if (clamp_reg)
            fac_calc = TWO_Q214;
        else
            fac_calc = ONE_Q214 + {2'b00, quot_reg};
        csum     = {1'b0, macc_reg} + COST_ROUND;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 6'd1;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 6'd0;
                if (acc)
                    state_next = (s_axis_tuser == OP_COST) ? ST_SQR : ST_DONE;
            end
            ST_SQR:
                if (cnt_reg == 6'(SQ_STEPS - 1))
                    state_next = ST_SUM;
            ST_SUM:
            begin
                cnt_next   = 6'd0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
                if (cnt_reg == 6'(HROOT_STEPS - 1))
                    state_next = ST_CINIT;
            ST_CINIT:
            begin
                cnt_next   = 6'd0;
                state_next = ST_CORD;
            end
            ST_CORD:
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                    state_next = ST_FACT;
            ST_FACT:
            begin
                cnt_next   = 6'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = ST_FAC;
            ST_FAC:
                state_next = ST_PRD;
            ST_PRD:
            begin
                cnt_next   = 6'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
                if (cnt_reg == 6'(MUL_STEPS - 1))
                    state_next = ST_FIN;
            ST_FIN:
                state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= 6'd0;
            out_vld_reg  <= 1'b0;
            peak_reg     <= ONE_Q214;
            coef_reg     <= 16'd256;
            road_dis_reg <= 1'b0;
            road_id_reg  <= 6'd0;
            area_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COEF:     coef_reg     <= cfg_data;
                    REG_ROAD_DIS: road_dis_reg <= cfg_data[0];
                    REG_ROAD_ID:  road_id_reg  <= cfg_data[5:0];
                    default:      ;
                endcase
            end
            if (acc && s_axis_tuser == OP_WRITE && in_rng)
                area_vld_reg[in_idx] <= 1'b1;
            if (acc && s_axis_tuser == OP_BEGIN)
                peak_reg <= ONE_Q214;
            else if (state_reg == ST_FAC && fac_calc > peak_reg)
                peak_reg <= fac_calc;
        end
    end

    // area cost table, registered read
    always_ff @(posedge clk)
    begin
        if (acc && s_axis_tuser == OP_WRITE && in_rng)
            area_mem[in_idx] <= in_val;
        if (acc)
            mem_rd_reg <= area_mem[in_idx];
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {res_max_reg, res_fac_reg, res_cost_reg};
        case (state_reg)
            ST_IDLE:
            begin
                ax_reg       <= mag33(in_ex, in_sx);
                ay_reg       <= mag33(in_ey, in_sy);
                az_reg       <= mag33(in_ez, in_sz);
                qx_reg       <= mag33(in_ex, in_sx);
                qy_reg       <= mag33(in_ey, in_sy);
                qz_reg       <= mag33(in_ez, in_sz);
                sx_reg       <= 66'd0;
                sy_reg       <= 66'd0;
                sz_reg       <= 66'd0;
                vert_reg     <= (in_ex == in_sx) && (in_ez == in_sz);
                hit_reg      <= in_rng && area_vld_reg[in_idx];
                road_ovr_reg <= road_dis_reg && (in_area == road_id_reg);
                res_cost_reg <= 48'd0;
                res_fac_reg  <= ONE_Q214;
                res_max_reg  <= (s_axis_tuser == OP_BEGIN) ? ONE_Q214 : peak_reg;
            end
            ST_SQR:
            begin
                sx_reg <= sx_next;
                sy_reg <= sy_next;
                sz_reg <= sz_next;
                qx_reg <= {qx_reg[31:0], 1'b0};
                qy_reg <= {qy_reg[31:0], 1'b0};
                qz_reg <= {qz_reg[31:0], 1'b0};
            end
            ST_SUM:
            begin
                hv_reg    <= {sx_reg + sz_reg, 16'd0};
                lv_reg    <= sx_reg + sz_reg + sy_reg;
                hrem_reg  <= 45'd0;
                hroot_reg <= 41'd0;
                lrem_reg  <= 37'd0;
                lroot_reg <= 33'd0;
            end
            ST_ROOT:
            begin
                hv_reg <= {hv_reg[79:0], 2'b00};
                if (hrem_sh >= htrial)
                begin
                    hrem_reg  <= hrem_sh - htrial;
                    hroot_reg <= {hroot_reg[39:0], 1'b1};
                end
                else
                begin
                    hrem_reg  <= hrem_sh;
                    hroot_reg <= {hroot_reg[39:0], 1'b0};
                end
                // length root has fewer digit pairs
                if (cnt_reg < 6'(LROOT_STEPS))
                begin
                    lv_reg <= {lv_reg[63:0], 2'b00};
                    if (lrem_sh >= ltrial)
                    begin
                        lrem_reg  <= lrem_sh - ltrial;
                        lroot_reg <= {lroot_reg[31:0], 1'b1};
                    end
                    else
                    begin
                        lrem_reg  <= lrem_sh;
                        lroot_reg <= {lroot_reg[31:0], 1'b0};
                    end
                end
            end
            ST_CINIT:
            begin
                cx_reg <= {3'b000, hroot_reg, 16'd0};
                cy_reg <= {3'b000, ay_reg, 24'd0};
                cz_reg <= 24'sd0;
            end
            ST_CORD:
            begin
                if (!cy_reg[59])
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + tz;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - tz;
                end
            end
            ST_FACT:
            begin
                zpos_reg  <= !cz_reg[23] && (cz_reg != 24'sd0);
                clamp_reg <= (fv[39:12] >= CLAMP_Q);
                dq_reg    <= fv[30:12];
                drem_reg  <= 5'd0;
                quot_reg  <= 14'd0;
            end
            ST_DIV:
            begin
                dq_reg <= {dq_reg[17:0], 1'b0};
                if (dsh >= DIV_BY)
                begin
                    drem_reg <= 5'(dsh - DIV_BY);
                    quot_reg <= {quot_reg[12:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dsh[4:0];
                    quot_reg <= {quot_reg[12:0], 1'b0};
                end
            end
            ST_FAC:
            begin
                fac_reg     <= fac_calc;
                res_fac_reg <= fac_calc;
                res_max_reg <= (fac_calc > peak_reg) ? fac_calc : peak_reg;
            end
            ST_PRD:
            begin
                p_reg    <= 32'(acost) * 32'(fac_reg);
                ml_reg   <= lroot_reg;
                macc_reg <= 66'd0;
            end
            ST_MUL:
            begin
                macc_reg <= {macc_reg[64:0], 1'b0} + (ml_reg[32] ? {34'd0, p_reg} : 66'd0);
                ml_reg   <= {ml_reg[31:0], 1'b0};
            end
            ST_FIN:
                // product stays below 2^66, so the rounded cost fits 48 bits
                res_cost_reg <= 48'(csum[66:22]);
            default:
                ;
        endcase
    end

endmodule
